/* rtl/core/audio_activity_source_selector_core_defines.svh */
// Assertion helpers shared by the selector core RTL.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef AUDIO_ACTIVITY_SOURCE_SELECTOR_CORE_DEFINES_SVH
`define AUDIO_ACTIVITY_SOURCE_SELECTOR_CORE_DEFINES_SVH

// Property checked on every rising clock edge outside of reset.
`define AASS_ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition in one cycle requires a result in the following cycle.
`define AASS_ASSERT_NEXT(label, cond, result, msg) \
  `AASS_ASSERT_CLK(label, (cond) |=> (result), msg)

`endif

/* rtl/core/aass_pkg.sv */
package aass_pkg;

  localparam int SOURCES     = 4;
  localparam int SRC_W       = $clog2(SOURCES);
  localparam int SAMPLE_BITS = 10;
  localparam int SUM_W       = 16;
  localparam int COUNT_W     = 8;
  localparam int CREDIT_W    = SUM_W + 1;
  localparam int BLINK_W     = 4;

  // Configuration port geometry.
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Stream widths, padded to whole bytes.
  localparam int IN_TDATA_W    = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_FIELDS_W  = SRC_W + 4 + SUM_W;
  localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W     = OUT_TDATA_W - OUT_FIELDS_W;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  // Register indexes (byte address divided by four).
  localparam logic [2:0] REG_ACT_THRESH         = 3'd0;
  localparam logic [2:0] REG_CREDIT_LIMIT       = 3'd1;
  localparam logic [2:0] REG_START_CREDIT       = 3'd2;
  localparam logic [2:0] REG_MIN_READING        = 3'd3;
  localparam logic [2:0] REG_SAMPLES_PER_SIDE   = 3'd4;

  // Register reset values.
  localparam logic [15:0]          RST_ACT_THRESH         = 16'd128;
  localparam logic [15:0]          RST_CREDIT_LIMIT       = 16'd512;
  localparam logic [7:0]           RST_START_CREDIT       = 8'd20;
  localparam logic [SAMPLE_BITS-1:0] RST_MIN_READING      = SAMPLE_BITS'(300);
  localparam logic [COUNT_W-1:0]   RST_SAMPLES_PER_SIDE   = COUNT_W'(40);

  typedef struct packed {
    logic [15:0]            act_thresh;
    logic [15:0]            credit_limit;
    logic [7:0]             start_credit;
    logic [SAMPLE_BITS-1:0] min_reading;
    logic [COUNT_W-1:0]     samples_per_side;
  } cfg_t;

  // Result of the measurement unit for one sample.
  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] activity;
  } meas_t;

  // Next-state view of the selector, as shown on the result stream.
  typedef struct packed {
    logic [SRC_W-1:0] source_select;
    logic             transmitter_on;
    logic             activity_light;
  } sel_status_t;

  // Saturating accumulate of one sample step into an activity sum.
  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SAMPLE_BITS-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {{(SUM_W + 1 - SAMPLE_BITS){1'b0}}, b};
    return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

endpackage

/* rtl/core/audio_activity_source_selector_core.sv */
// Audio activity source selector. Each input transaction carries one converter
// sample taken from the source and side named in the most recent result; each
// accepted sample produces exactly one result transaction, and a new sample is
// accepted in every cycle as long as the result side keeps up. That figure is
// set by the single state update per sample: the sample is registered, runs
// combinationally through the measurement unit and the scan/hold selector,
// and lands in the result register. Results report the source and side to
// sample next, the transmitter enable, the debug light, and, on the sample
// that completes a measurement, its activity value.
// The configuration registers sit on an APB port at byte addresses 0x00
// (activity threshold), 0x04 (credit limit), 0x08 (start credit), 0x0C
// (minimum reading) and 0x10 (samples per side); write them only while no
// transaction is in flight.
`include "audio_activity_source_selector_core_defines.svh"

module audio_activity_source_selector_core (
  input  logic                              clk,
  input  logic                              rst_n,
  // Sample stream.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [9:0] sample, upper bits ignored.
  input  logic [aass_pkg::IN_TDATA_W-1:0]   in_tdata,
  // Result stream.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [1:0] source_select, [2] side_select, [3] transmitter_on,
  // [4] activity_light, [5] measure_done, [21:6] activity_value, rest zero.
  output logic [aass_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // Configuration port.
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [aass_pkg::ADDR_W-1:0]       cfg_paddr,
  input  logic [aass_pkg::DATA_W-1:0]       cfg_pwdata,
  output logic [aass_pkg::DATA_W-1:0]       cfg_prdata,
  output logic                              cfg_pready
);
  import aass_pkg::*;

  // Configuration registers. A write lands on the access phase of an APB
  // transaction; the port never inserts wait states.
  cfg_t       cfg_r;
  logic       cfg_we;
  logic [2:0] cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx    = cfg_paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.act_thresh         <= RST_ACT_THRESH;
      cfg_r.credit_limit       <= RST_CREDIT_LIMIT;
      cfg_r.start_credit       <= RST_START_CREDIT;
      cfg_r.min_reading        <= RST_MIN_READING;
      cfg_r.samples_per_side   <= RST_SAMPLES_PER_SIDE;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_ACT_THRESH:         cfg_r.act_thresh         <= cfg_pwdata[15:0];
        REG_CREDIT_LIMIT:       cfg_r.credit_limit       <= cfg_pwdata[15:0];
        REG_START_CREDIT:       cfg_r.start_credit       <= cfg_pwdata[7:0];
        REG_MIN_READING:        cfg_r.min_reading        <= cfg_pwdata[SAMPLE_BITS-1:0];
        REG_SAMPLES_PER_SIDE:   cfg_r.samples_per_side   <= cfg_pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ACT_THRESH:         cfg_prdata = DATA_W'(cfg_r.act_thresh);
      REG_CREDIT_LIMIT:       cfg_prdata = DATA_W'(cfg_r.credit_limit);
      REG_START_CREDIT:       cfg_prdata = DATA_W'(cfg_r.start_credit);
      REG_MIN_READING:        cfg_prdata = DATA_W'(cfg_r.min_reading);
      REG_SAMPLES_PER_SIDE:   cfg_prdata = DATA_W'(cfg_r.samples_per_side);
      default:                cfg_prdata = '0;
    endcase
  end

  // Input register. The held sample advances whenever the result register is
  // empty or is being emptied in this cycle, so one more sample can still be
  // taken while a finished result waits for the consumer.
  logic                   stage_valid_r, stage_valid_nxt;
  logic [SAMPLE_BITS-1:0] sample_r;
  logic                   in_fire;
  logic                   step;

  assign step            = stage_valid_r & (~out_tvalid | out_tready);
  assign in_tready       = ~stage_valid_r | step;
  assign in_fire         = in_tvalid & in_tready;
  assign stage_valid_nxt = in_fire | (stage_valid_r & ~step);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      sample_r <= in_tdata[SAMPLE_BITS-1:0];
    end
  end

  // Measurement of left and right activity, then the scan/hold decision.
  meas_t       meas;
  logic        side_sel;
  sel_status_t status;

  aass_measure u_measure (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .sample   (sample_r),
    .cfg      (cfg_r),
    .meas     (meas),
    .side_sel (side_sel)
  );

  aass_select u_select (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .meas   (meas),
    .cfg    (cfg_r),
    .status (status)
  );

  // Result register.
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  assign out_valid_nxt = step | (out_valid_r & ~out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_tdata_r <= {{OUT_PAD_W{1'b0}}, meas.activity, meas.done,
                      status.activity_light, status.transmitter_on, side_sel,
                      status.source_select};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

  // An accepted sample always occupies the input register in the next cycle.
  `AASS_ASSERT_NEXT(a_accept_fills_stage, in_fire, stage_valid_r,
                    "accepted sample did not reach the input register")

  // A stalled result register must hold back the pending sample.
  `AASS_ASSERT_NEXT(a_stall_keeps_sample, stage_valid_r && out_tvalid && !out_tready,
                    stage_valid_r, "pending sample dropped while the result was stalled")

  // An empty input register never refuses a transaction.
  `AASS_ASSERT_CLK(a_empty_stage_ready, !stage_valid_r |-> in_tready,
                   "input refused while the input register was empty")

  // Activity is reported only on the sample that completes a measurement.
  `AASS_ASSERT_CLK(a_activity_only_on_done,
                   out_tvalid && !out_tdata[SRC_W+3] |-> out_tdata[SRC_W+4+:SUM_W] == '0,
                   "nonzero activity on a result without a completed measurement")

endmodule

/* rtl/core/aass_measure.sv */
module aass_measure (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              step,
  input  logic [aass_pkg::SAMPLE_BITS-1:0]  sample,
  input  aass_pkg::cfg_t                    cfg,
  output aass_pkg::meas_t                   meas,
  output logic                              side_sel
);
  import aass_pkg::*;

  logic                   side_r, side_nxt;
  logic [COUNT_W-1:0]     count_r, count_nxt;
  logic [SAMPLE_BITS-1:0] prev_r, prev_nxt;
  logic [SUM_W-1:0]       rise_r, rise_nxt;
  logic [SUM_W-1:0]       fall_r, fall_nxt;
  logic [COUNT_W-1:0]     count_inc;

  always_comb begin
    side_nxt      = side_r;
    count_nxt     = count_r;
    prev_nxt      = prev_r;
    rise_nxt      = rise_r;
    fall_nxt      = fall_r;
    count_inc     = count_r + COUNT_W'(1);
    meas.done     = 1'b0;
    meas.activity = '0;

    if (sample < cfg.min_reading) begin
      // A dropout aborts the whole measurement with zero activity.
      meas.done = 1'b1;
    end else begin
      // The first sample of each side only seeds the previous value.
      if (count_r != '0) begin
        if (sample > prev_r) begin
          rise_nxt = sat_add(rise_r, sample - prev_r);
        end else if (sample < prev_r) begin
          fall_nxt = sat_add(fall_r, prev_r - sample);
        end
      end
      prev_nxt  = sample;
      count_nxt = count_inc;
      if (count_inc >= cfg.samples_per_side || count_inc == '0) begin
        if (!side_r) begin
          side_nxt  = 1'b1;
          count_nxt = '0;
          prev_nxt  = '0;
        end else begin
          meas.done     = 1'b1;
          meas.activity = (rise_nxt > fall_nxt) ? fall_nxt : rise_nxt;
        end
      end
    end

    if (meas.done) begin
      side_nxt  = 1'b0;
      count_nxt = '0;
      prev_nxt  = '0;
      rise_nxt  = '0;
      fall_nxt  = '0;
    end
  end

  assign side_sel = side_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r  <= 1'b0;
      count_r <= '0;
      prev_r  <= '0;
      rise_r  <= '0;
      fall_r  <= '0;
    end else if (step) begin
      side_r  <= side_nxt;
      count_r <= count_nxt;
      prev_r  <= prev_nxt;
      rise_r  <= rise_nxt;
      fall_r  <= fall_nxt;
    end
  end

endmodule

/* rtl/core/aass_select.sv */
module aass_select (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  aass_pkg::meas_t       meas,
  input  aass_pkg::cfg_t        cfg,
  output aass_pkg::sel_status_t status
);
  import aass_pkg::*;

  logic                holding_r, holding_nxt;
  logic [SRC_W-1:0]    scan_r, scan_nxt;
  logic [SRC_W-1:0]    held_r, held_nxt;
  logic [SRC_W-1:0]    best_src_r, best_src_nxt;
  logic [SUM_W-1:0]    best_act_r, best_act_nxt;
  logic [CREDIT_W-1:0] credit_r, credit_nxt;
  logic [BLINK_W-1:0]  blink_r, blink_nxt;
  logic                light_r, light_nxt;

  always_comb begin
    holding_nxt  = holding_r;
    scan_nxt     = scan_r;
    held_nxt     = held_r;
    best_src_nxt = best_src_r;
    best_act_nxt = best_act_r;
    credit_nxt   = credit_r;
    blink_nxt    = blink_r;
    light_nxt    = light_r;

    if (meas.done) begin
      if (holding_r) begin
        if (meas.activity > cfg.act_thresh) begin
          if (credit_r < {1'b0, cfg.credit_limit}) begin
            credit_nxt = credit_r + CREDIT_W'(2);
          end
          light_nxt = 1'b1;
        end else begin
          if (credit_r != '0) begin
            credit_nxt = credit_r - CREDIT_W'(1);
          end
          light_nxt = 1'b0;
        end
        // Credit exhausted: release the source and restart the scan.
        if (credit_nxt == '0) begin
          holding_nxt  = 1'b0;
          scan_nxt     = '0;
          best_src_nxt = '0;
          best_act_nxt = '0;
        end
      end else begin
        if (meas.activity > best_act_r) begin
          best_act_nxt = meas.activity;
          best_src_nxt = scan_r;
        end
        if (scan_r == SRC_W'(SOURCES - 1)) begin
          scan_nxt  = '0;
          blink_nxt = blink_r + BLINK_W'(1);
          light_nxt = ~blink_nxt[BLINK_W-1];
          if (best_act_nxt >= cfg.act_thresh) begin
            held_nxt    = best_src_nxt;
            holding_nxt = 1'b1;
            credit_nxt  = CREDIT_W'(cfg.start_credit);
            blink_nxt   = '0;
          end
          best_src_nxt = '0;
          best_act_nxt = '0;
        end else begin
          scan_nxt = scan_r + SRC_W'(1);
        end
      end
    end
  end

  assign status.source_select  = holding_nxt ? held_nxt : scan_nxt;
  assign status.transmitter_on = holding_nxt;
  assign status.activity_light = light_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      holding_r  <= 1'b0;
      scan_r     <= '0;
      held_r     <= '0;
      best_src_r <= '0;
      best_act_r <= '0;
      credit_r   <= '0;
      blink_r    <= '0;
      light_r    <= 1'b0;
    end else if (step) begin
      holding_r  <= holding_nxt;
      scan_r     <= scan_nxt;
      held_r     <= held_nxt;
      best_src_r <= best_src_nxt;
      best_act_r <= best_act_nxt;
      credit_r   <= credit_nxt;
      blink_r    <= blink_nxt;
      light_r    <= light_nxt;
    end
  end

endmodule
